// ===== sv/conv3x3_normalized_clamp_macros.svh =====
// Assertion macros used by the port-level checker of the 3x3 filter block.
`ifndef CONV3X3_NORMALIZED_CLAMP_MACROS_SVH
`define CONV3X3_NORMALIZED_CLAMP_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while reset is low.
`define CNV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cnv assertion failed");

// Next-cycle implication, sampled on i_clk and disabled while reset is low.
`define CNV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cnv assertion failed");

`endif

// ===== sv/cnv_pkg.sv =====
// Shared constants and types of the 3x3 normalized convolution filter.
package cnv_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int COEF_FRAC_BITS = 8;

    localparam int PIX_W   = 8;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W = COL_W + 1;
    localparam int COEF_W  = 16;
    localparam int ROW_COEF_W = 3 * COEF_W;
    localparam int N_TAPS  = 9;
    localparam int TAP_W   = $clog2(N_TAPS);
    localparam int PROD_W  = COEF_W + PIX_W + 1;
    localparam int ACC_W   = PROD_W + 4;
    localparam int KSUM_W  = COEF_W + 4;
    localparam int DIV_W   = ACC_W + 2;
    localparam int QUOT_W  = PIX_W;
    localparam int QCNT_W  = $clog2(QUOT_W);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int APB_DW = 64;
    localparam int APB_AW = 5;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [1:0] REG_COEF_TOP    = 2'd1;
    localparam logic [1:0] REG_COEF_MID    = 2'd2;
    localparam logic [1:0] REG_COEF_BOT    = 2'd3;

    typedef logic [N_TAPS-1:0][COEF_W-1:0] t_coefs;

    // One filter job: nine window pixels (row-major, top-left first) and its place.
    typedef struct packed {
        logic [N_TAPS-1:0][PIX_W-1:0] pix;
        logic [COL_W-1:0]             col;
        logic [ROW_W-1:0]             row;
        logic                         last;
    } t_job;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_result;

endpackage

// ===== sv/cnv_fifo.sv =====
// Short job queue between the window front end and the arithmetic back end.
module cnv_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cnv_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output cnv_pkg::t_job o_job,
    output logic          o_empty
);

    cnv_pkg::t_job                r_mem [cnv_pkg::FIFO_DEPTH];
    logic [cnv_pkg::FIFO_AW-1:0]  r_wr;
    logic [cnv_pkg::FIFO_AW-1:0]  r_rd;
    logic [cnv_pkg::FIFO_AW:0]    r_cnt;

    assign o_full  = (r_cnt == (cnv_pkg::FIFO_AW+1)'(cnv_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/cnv_front.sv =====
// Front end: takes items, keeps the line buffers and window, and builds filter jobs.
module cnv_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_kind,
    input  logic [cnv_pkg::PIX_W-1:0]   i_pixel,
    input  logic [cnv_pkg::WIDTH_W-1:0] i_width,
    output logic                        o_push,
    output cnv_pkg::t_job               o_job,
    input  logic                        i_full
);

    typedef enum logic [6:0] {
        F_IDLE  = 7'b0000001,
        F_PRD   = 7'b0000010,
        F_FL    = 7'b0000100,
        F_FC    = 7'b0001000,
        F_FR    = 7'b0010000,
        F_PUSH1 = 7'b0100000,
        F_PUSH2 = 7'b1000000
    } t_fstate;

    t_fstate r_state;

    logic [cnv_pkg::PIX_W-1:0] r_line_above  [cnv_pkg::MAX_WIDTH];
    logic [cnv_pkg::PIX_W-1:0] r_line_middle [cnv_pkg::MAX_WIDTH];
    logic [cnv_pkg::PIX_W-1:0] r_rd_a;
    logic [cnv_pkg::PIX_W-1:0] r_rd_m;

    logic [5:0][cnv_pkg::PIX_W-1:0] r_win;
    logic [cnv_pkg::COL_W-1:0]      r_col;
    logic [1:0]                     r_rows;
    logic [cnv_pkg::ROW_W-1:0]      r_row;
    logic [cnv_pkg::PIX_W-1:0]      r_pix;
    logic [1:0][cnv_pkg::PIX_W-1:0] r_ft;
    logic [1:0][cnv_pkg::PIX_W-1:0] r_fm;
    cnv_pkg::t_job                  r_job_a;
    cnv_pkg::t_job                  r_job_b;
    logic                           r_has_b;

    logic [cnv_pkg::WIDTH_W-1:0]    w_eff;
    logic                           c_last;
    logic [cnv_pkg::COL_W-1:0]      col_l;
    logic [cnv_pkg::COL_W-1:0]      col_r;
    logic [cnv_pkg::ROW_W-1:0]      prow;
    logic                           rd_en;
    logic [cnv_pkg::COL_W-1:0]      rd_addr;
    logic                           accept;
    logic [2:0][cnv_pkg::PIX_W-1:0] cur;
    cnv_pkg::t_job                  job_a;
    cnv_pkg::t_job                  job_b;
    cnv_pkg::t_job                  job_f;
    logic                           has_a;
    logic                           has_b;

    assign o_ready = (r_state == F_IDLE);
    assign accept  = i_valid && o_ready;

    // Effective row width and the column neighbors.
    always_comb begin
        if (i_width == '0) begin
            w_eff = cnv_pkg::WIDTH_W'(1);
        end else if (i_width > cnv_pkg::WIDTH_W'(cnv_pkg::MAX_WIDTH)) begin
            w_eff = cnv_pkg::WIDTH_W'(cnv_pkg::MAX_WIDTH);
        end else begin
            w_eff = i_width;
        end
        c_last = (({1'b0, r_col} + 1'b1) >= w_eff);
        col_l  = (r_col == '0) ? r_col : r_col - 1'b1;
        col_r  = c_last ? r_col : r_col + 1'b1;
        prow   = (r_row == '0) ? cnv_pkg::ROW_W'(cnv_pkg::MAX_HEIGHT - 1) : r_row - 1'b1;
    end

    // Line buffer read address, one per cycle.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_col;
        case (r_state)
            F_IDLE: begin
                rd_en   = accept;
                rd_addr = i_kind ? col_l : r_col;
            end
            F_FL: begin
                rd_en   = 1'b1;
                rd_addr = r_col;
            end
            F_FC: begin
                rd_en   = 1'b1;
                rd_addr = col_r;
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = r_col;
            end
        endcase
    end

    // Line buffers: registered read, written in the read state of a pixel item.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_a <= r_line_above[rd_addr];
            r_rd_m <= r_line_middle[rd_addr];
        end
        if (r_state == F_PRD) begin
            r_line_above[r_col]  <= cur[1];
            r_line_middle[r_col] <= r_pix;
        end
    end

    // Window columns for a pixel item; the first row fills all three rows.
    always_comb begin
        cur[0] = (r_rows != '0) ? r_rd_a : r_pix;
        cur[1] = (r_rows != '0) ? r_rd_m : r_pix;
        cur[2] = r_pix;
        has_a  = (r_rows != '0) && (r_col != '0);
        has_b  = (r_rows != '0) && c_last;
        job_a  = '0;
        job_b  = '0;
        job_f  = '0;
        for (int r = 0; r < 3; r++) begin
            job_a.pix[r*3]     = r_win[r];
            job_a.pix[r*3 + 1] = r_win[3 + r];
            job_a.pix[r*3 + 2] = cur[r];
            job_b.pix[r*3]     = (r_col == '0) ? cur[r] : r_win[3 + r];
            job_b.pix[r*3 + 1] = cur[r];
            job_b.pix[r*3 + 2] = cur[r];
        end
        job_a.col  = r_col - 1'b1;
        job_a.row  = prow;
        job_a.last = !has_b;
        job_b.col  = r_col;
        job_b.row  = prow;
        job_b.last = 1'b1;
        // Flush job: the bottom row repeats the middle row.
        job_f.pix[0] = r_ft[0];
        job_f.pix[1] = r_ft[1];
        job_f.pix[2] = r_rd_a;
        job_f.pix[3] = r_fm[0];
        job_f.pix[4] = r_fm[1];
        job_f.pix[5] = r_rd_m;
        job_f.pix[6] = r_fm[0];
        job_f.pix[7] = r_fm[1];
        job_f.pix[8] = r_rd_m;
        job_f.col    = r_col;
        job_f.row    = prow;
        job_f.last   = 1'b1;
    end

    assign o_push = ((r_state == F_PUSH1) || (r_state == F_PUSH2)) && !i_full;
    assign o_job  = (r_state == F_PUSH1) ? r_job_a : r_job_b;

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= i_pixel;
        end
        if (r_state == F_FL) begin
            r_ft[0] <= r_rd_a;
            r_fm[0] <= r_rd_m;
        end
        if (r_state == F_FC) begin
            r_ft[1] <= r_rd_a;
            r_fm[1] <= r_rd_m;
        end
        if (r_state == F_PRD) begin
            r_job_a <= job_a;
            r_job_b <= job_b;
            r_has_b <= has_b;
        end
        if (r_state == F_FR) begin
            r_job_b <= job_f;
        end
    end

    // Sequencer, window and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_win   <= '0;
            r_col   <= '0;
            r_rows  <= '0;
            r_row   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        if (!i_kind) begin
                            r_state <= F_PRD;
                        end else if (r_rows == '0) begin
                            r_col  <= '0;
                            r_row  <= '0;
                            r_win  <= '0;
                        end else begin
                            r_state <= F_FL;
                        end
                    end
                end
                F_PRD: begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[k]     <= (r_col == '0) ? cur[k] : r_win[3 + k];
                        r_win[3 + k] <= cur[k];
                    end
                    if (c_last) begin
                        r_col <= '0;
                        if (r_rows != 2'd2) begin
                            r_rows <= r_rows + 1'b1;
                        end
                        r_row <= (r_row == cnv_pkg::ROW_W'(cnv_pkg::MAX_HEIGHT - 1)) ?
                                 '0 : r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    if (has_a) begin
                        r_state <= F_PUSH1;
                    end else if (has_b) begin
                        r_state <= F_PUSH2;
                    end else begin
                        r_state <= F_IDLE;
                    end
                end
                F_FL: begin
                    r_state <= F_FC;
                end
                F_FC: begin
                    r_state <= F_FR;
                end
                F_FR: begin
                    if (c_last) begin
                        r_col  <= '0;
                        r_rows <= '0;
                        r_row  <= '0;
                        r_win  <= '0;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    r_state <= F_PUSH2;
                end
                F_PUSH1: begin
                    if (!i_full) begin
                        r_state <= r_has_b ? F_PUSH2 : F_IDLE;
                    end
                end
                F_PUSH2: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/cnv_back.sv =====
// Back end: weighted sum, rounded division by the kernel sum, clamp and output register.
module cnv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    output logic            o_pop,
    input  cnv_pkg::t_job   i_job,
    input  cnv_pkg::t_coefs i_coefs,
    output cnv_pkg::t_result o_res,
    output logic            o_valid,
    input  logic            i_ready
);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_MAC  = 5'b00010,
        B_PREP = 5'b00100,
        B_DIV  = 5'b01000,
        B_OUT  = 5'b10000
    } t_bstate;

    t_bstate                             r_state;
    cnv_pkg::t_job                       r_job;
    logic [cnv_pkg::TAP_W-1:0]           r_k;
    logic signed [cnv_pkg::ACC_W-1:0]    r_acc;
    logic signed [cnv_pkg::KSUM_W-1:0]   r_ksum;
    logic [cnv_pkg::DIV_W-1:0]           r_rem;
    logic [cnv_pkg::DIV_W-1:0]           r_dsh;
    logic [cnv_pkg::QUOT_W-1:0]          r_q;
    logic [cnv_pkg::QCNT_W-1:0]          r_i;
    cnv_pkg::t_result                    r_res;
    logic                                r_valid;

    logic signed [cnv_pkg::KSUM_W-1:0]   ksum;
    logic signed [cnv_pkg::PROD_W-1:0]   prod;
    logic signed [cnv_pkg::KSUM_W-1:0]   dsr;
    logic [cnv_pkg::ACC_W-1:0]           abs_s;
    logic [cnv_pkg::KSUM_W-1:0]          abs_d;
    logic                                neg;
    logic [cnv_pkg::DIV_W-1:0]           num;
    logic [cnv_pkg::DIV_W-1:0]           den;
    logic                                load_out;

    // Kernel sum, refreshed every cycle from the coefficient registers.
    always_comb begin
        ksum = '0;
        for (int k = 0; k < cnv_pkg::N_TAPS; k++) begin
            ksum = ksum + cnv_pkg::KSUM_W'(signed'(i_coefs[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_ksum <= ksum;
    end

    // One tap product per cycle.
    assign prod = $signed(i_coefs[r_k]) * $signed({1'b0, r_job.pix[r_k]});

    // Operands of the rounded division: q = (2|s| + |d|) / (2|d|).
    always_comb begin
        dsr   = (r_ksum != '0) ? r_ksum : cnv_pkg::KSUM_W'(1 << cnv_pkg::COEF_FRAC_BITS);
        abs_s = r_acc[cnv_pkg::ACC_W-1] ? cnv_pkg::ACC_W'(-r_acc) : cnv_pkg::ACC_W'(r_acc);
        abs_d = dsr[cnv_pkg::KSUM_W-1] ? cnv_pkg::KSUM_W'(-dsr) : cnv_pkg::KSUM_W'(dsr);
        neg   = r_acc[cnv_pkg::ACC_W-1] != dsr[cnv_pkg::KSUM_W-1];
        num   = (cnv_pkg::DIV_W'(abs_s) << 1) + cnv_pkg::DIV_W'(abs_d);
        den   = cnv_pkg::DIV_W'(abs_d) << 1;
    end

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign load_out = (r_state == B_OUT) && (!r_valid || i_ready);
    assign o_res    = r_res;
    assign o_valid  = r_valid;

    // Result register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_res.pixel <= r_q;
            r_res.col   <= r_job.col;
            r_res.row   <= r_job.row;
            r_res.last  <= r_job.last;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job <= i_job;
                r_acc <= '0;
                r_k   <= '0;
            end
            B_MAC: begin
                r_acc <= r_acc + cnv_pkg::ACC_W'(prod);
                r_k   <= r_k + 1'b1;
            end
            B_PREP: begin
                r_rem <= num;
                r_dsh <= den << (cnv_pkg::QUOT_W - 1);
                r_i   <= cnv_pkg::QCNT_W'(cnv_pkg::QUOT_W - 1);
                if (neg) begin
                    r_q <= '0;
                end else if (num >= (den << cnv_pkg::QUOT_W)) begin
                    r_q <= '1;
                end else begin
                    r_q <= '0;
                end
            end
            B_DIV: begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[cnv_pkg::QUOT_W-2:0], (r_rem >= r_dsh)};
                r_dsh <= r_dsh >> 1;
                r_i   <= r_i - 1'b1;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // Sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= B_MAC;
                    end
                end
                B_MAC: begin
                    if (r_k == cnv_pkg::TAP_W'(cnv_pkg::N_TAPS - 1)) begin
                        r_state <= B_PREP;
                    end
                end
                B_PREP: begin
                    if (neg || (num >= (den << cnv_pkg::QUOT_W))) begin
                        r_state <= B_OUT;
                    end else begin
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (r_i == '0) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (load_out) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/conv3x3_normalized_clamp.sv =====
// Top level of the 3x3 normalized convolution filter with configuration registers.
//
// Pixels arrive in raster order; each output is the 3x3 neighborhood weighted by
// signed Q8.8 coefficients, divided by the kernel sum (or by 256 when it is zero),
// rounded half away from zero and clamped to 0..255. Borders are replicated and
// results lag one row and one column; flush items emit the final row. The front
// end takes a new item only while idle: a pixel passes its read state, a flush
// reads the left, centre and right columns, and each then queues any jobs, waiting
// while the queue is full. The back end takes a job from the queue, accumulates
// the nine taps on its single multiply-accumulate unit, sets up the division, runs
// the bit-serial divider and loads the output register before it takes the next
// job; a result that clamps skips the divider. A four-job queue lets the front end
// run ahead of the back end. The line buffers need no clearing after reset.
module conv3x3_normalized_clamp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [7:0]                   i_s_axis_tdata,  // pixel[7:0]
    input  logic                         i_s_axis_tuser,  // kind[0]
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [31:0]                  o_m_axis_tdata,  // out_pixel[7:0], out_col[17:8],
                                                          // out_row[29:18], zero[31:30]
    output logic                         o_m_axis_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cnv_pkg::APB_AW-1:0]   paddr,
    input  logic [cnv_pkg::APB_DW-1:0]   pwdata,
    output logic [cnv_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    logic [cnv_pkg::WIDTH_W-1:0]     r_image_width;
    logic [cnv_pkg::ROW_COEF_W-1:0]  r_coef_top;
    logic [cnv_pkg::ROW_COEF_W-1:0]  r_coef_mid;
    logic [cnv_pkg::ROW_COEF_W-1:0]  r_coef_bot;

    logic [1:0]        reg_idx;
    logic              cfg_wr;
    cnv_pkg::t_coefs   coefs;
    logic              push;
    cnv_pkg::t_job     push_job;
    logic              full;
    logic              pop;
    cnv_pkg::t_job     head_job;
    logic              empty;
    cnv_pkg::t_result  res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[cnv_pkg::APB_AW-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= cnv_pkg::WIDTH_W'(cnv_pkg::MAX_WIDTH);
            r_coef_top    <= '0;
            r_coef_mid    <= cnv_pkg::ROW_COEF_W'(1 << (cnv_pkg::COEF_W + cnv_pkg::COEF_FRAC_BITS));
            r_coef_bot    <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                cnv_pkg::REG_IMAGE_WIDTH: r_image_width <= pwdata[cnv_pkg::WIDTH_W-1:0];
                cnv_pkg::REG_COEF_TOP:    r_coef_top    <= pwdata[cnv_pkg::ROW_COEF_W-1:0];
                cnv_pkg::REG_COEF_MID:    r_coef_mid    <= pwdata[cnv_pkg::ROW_COEF_W-1:0];
                cnv_pkg::REG_COEF_BOT:    r_coef_bot    <= pwdata[cnv_pkg::ROW_COEF_W-1:0];
                default:                  r_coef_bot    <= r_coef_bot;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            cnv_pkg::REG_IMAGE_WIDTH: prdata = cnv_pkg::APB_DW'(r_image_width);
            cnv_pkg::REG_COEF_TOP:    prdata = cnv_pkg::APB_DW'(r_coef_top);
            cnv_pkg::REG_COEF_MID:    prdata = cnv_pkg::APB_DW'(r_coef_mid);
            cnv_pkg::REG_COEF_BOT:    prdata = cnv_pkg::APB_DW'(r_coef_bot);
            default:                  prdata = '0;
        endcase
    end

    // Coefficients in tap order, top-left first.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            coefs[c]     = r_coef_top[c*cnv_pkg::COEF_W +: cnv_pkg::COEF_W];
            coefs[3 + c] = r_coef_mid[c*cnv_pkg::COEF_W +: cnv_pkg::COEF_W];
            coefs[6 + c] = r_coef_bot[c*cnv_pkg::COEF_W +: cnv_pkg::COEF_W];
        end
    end

    cnv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_kind  (i_s_axis_tuser),
        .i_pixel (i_s_axis_tdata),
        .i_width (r_image_width),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    cnv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty)
    );

    cnv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .o_pop   (pop),
        .i_job   (head_job),
        .i_coefs (coefs),
        .o_res   (res),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {2'b00, res.row, res.col, res.pixel};
    assign o_m_axis_tlast = res.last;

endmodule

// ===== sv/cnv_checker.sv =====
// Port-level checker of the 3x3 filter, bound to the top level.
`include "conv3x3_normalized_clamp_macros.svh"

module cnv_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_axis_tvalid,
    input logic                       o_s_axis_tready,
    input logic                       i_s_axis_tuser,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [31:0]                o_m_axis_tdata,
    input logic                       o_m_axis_tlast,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [cnv_pkg::APB_AW-1:0] paddr,
    input logic [cnv_pkg::APB_DW-1:0] pwdata,
    input logic [cnv_pkg::APB_DW-1:0] prdata,
    input logic                       pready
);

    // No result is pending right after reset.
    `CNV_ASSERT_NOW(a_no_out_after_reset, $rose(i_rst_n), !o_m_axis_tvalid)

    // A pixel item always keeps the front end busy for the next cycle.
    `CNV_ASSERT_NEXT(a_pixel_busy, i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser,
        !o_s_axis_tready)

    // A stalled result holds its payload.
    `CNV_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))

    // A width write reads back on the following cycle.
    `CNV_ASSERT_NEXT(a_width_readback, psel && penable && pwrite && pready && (paddr == '0),
        (paddr != '0) || (prdata[cnv_pkg::WIDTH_W-1:0] == $past(pwdata[cnv_pkg::WIDTH_W-1:0])))

endmodule

bind conv3x3_normalized_clamp cnv_checker u_cnv_checker (.*);

// ===== dv/conv3x3_normalized_clamp_checker.sv =====
// Checker of the 3x3 filter: snoops the register port and both streams, predicts, compares.
module conv3x3_normalized_clamp_checker
    import cnv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [7:0]        i_s_tdata,
    input  logic              i_s_tuser,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [31:0]       i_m_tdata,
    input  logic              i_m_tlast,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    input  logic              i_pready,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_seen
);

    // Predictor copy of registers and filter state.
    logic [WIDTH_W-1:0]    width_reg;
    logic [ROW_COEF_W-1:0] coef_rows [3];
    logic [7:0]            line_top [MAX_WIDTH];
    logic [7:0]            line_mid [MAX_WIDTH];
    logic [7:0]            win [6];
    int                    col_pos;
    int                    rows_filled;
    int                    row_pos;
    t_result               pixels_due [$];

    assign o_pending = pixels_due.size();

    task automatic report(input string msg);
        if (o_mismatches < 40) $display("mismatch: %s", msg);
        o_mismatches++;
    endtask

    function automatic longint coef_at(input int r, input int k);
        return longint'($signed(coef_rows[r][16*k +: 16]));
    endfunction

    // p holds left, centre, right of the top, middle and bottom rows.
    function automatic logic [7:0] weigh(input int p[9]);
        longint acc, ksum, d, as_, ad, q;
        bit neg;
        acc = 0;
        ksum = 0;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                acc += coef_at(r, k) * p[3*r + k];
                ksum += coef_at(r, k);
            end
        end
        d = (ksum != 0) ? ksum : (64'sd1 <<< COEF_FRAC_BITS);
        as_ = acc < 0 ? -acc : acc;
        ad = d < 0 ? -d : d;
        neg = (acc < 0) != (d < 0);
        q = (2 * as_ + ad) / (2 * ad);
        if (neg) q = -q;
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    function automatic logic [ROW_W-1:0] row_before();
        return (row_pos == 0) ? ROW_W'(MAX_HEIGHT - 1) : ROW_W'(row_pos - 1);
    endfunction

    task automatic restart_image();
        col_pos = 0;
        rows_filled = 0;
        row_pos = 0;
        for (int k = 0; k < 6; k++) win[k] = 8'd0;
    endtask

    task automatic predict_item(input logic kind, input logic [7:0] pix);
        int w, c, n, l, r;
        int cur[3];
        int p[9];
        t_result res[2];
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : int'(width_reg));
        c = col_pos;
        n = 0;
        if (kind == 1'b0) begin
            cur[0] = rows_filled ? line_top[c] : pix;
            cur[1] = rows_filled ? line_mid[c] : pix;
            cur[2] = pix;
            line_top[c] = cur[1][7:0];
            line_mid[c] = pix;
            for (int k = 0; k < 3; k++) begin
                p[3*k] = win[k];
                p[3*k + 1] = win[3 + k];
                p[3*k + 2] = cur[k];
            end
            if (c == 0) begin
                for (int k = 0; k < 3; k++) begin
                    win[k] = cur[k][7:0];
                    win[3 + k] = cur[k][7:0];
                end
            end else begin
                if (rows_filled != 0) begin
                    res[n] = '{weigh(p), COL_W'(c - 1), row_before(), 1'b0};
                    n++;
                end
                for (int k = 0; k < 3; k++) begin
                    win[k] = win[3 + k];
                    win[3 + k] = cur[k][7:0];
                end
            end
            // The window now holds the columns left of and at c.
            if (c + 1 >= w) begin
                if (rows_filled != 0) begin
                    for (int k = 0; k < 3; k++) begin
                        p[3*k] = win[k];
                        p[3*k + 1] = win[3 + k];
                        p[3*k + 2] = cur[k];
                    end
                    res[n] = '{weigh(p), COL_W'(c), row_before(), 1'b0};
                    n++;
                end
                col_pos = 0;
                if (rows_filled < 2) rows_filled++;
                row_pos = (row_pos + 1 >= MAX_HEIGHT) ? 0 : row_pos + 1;
            end else begin
                col_pos = c + 1;
            end
        end else if (rows_filled == 0) begin
            restart_image();
        end else begin
            // Flush: the bottom row replicates the middle one.
            l = c ? c - 1 : 0;
            r = (c + 1 < w) ? c + 1 : c;
            p = '{line_top[l], line_top[c], line_top[r],
                  line_mid[l], line_mid[c], line_mid[r],
                  line_mid[l], line_mid[c], line_mid[r]};
            res[n] = '{weigh(p), COL_W'(c), row_before(), 1'b0};
            n++;
            if (c + 1 >= w) restart_image();
            else col_pos = c + 1;
        end
        if (n > 0) res[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++) pixels_due.push_back(res[k]);
    endtask

    task automatic compare_result();
        t_result want;
        o_seen++;
        if (pixels_due.size() == 0) begin
            report($sformatf("unexpected result data=%h last=%b", i_m_tdata, i_m_tlast));
        end else begin
            want = pixels_due.pop_front();
            if (i_m_tdata[7:0] !== want.pixel)
                report($sformatf("pixel %0d want %0d (r%0d c%0d)", i_m_tdata[7:0],
                    want.pixel, want.row, want.col));
            if (i_m_tdata[17:8] !== want.col)
                report($sformatf("col %0d want %0d", i_m_tdata[17:8], want.col));
            if (i_m_tdata[29:18] !== want.row)
                report($sformatf("row %0d want %0d", i_m_tdata[29:18], want.row));
            if (i_m_tdata[31:30] !== 2'b00)
                report($sformatf("padding bits %b", i_m_tdata[31:30]));
            if (i_m_tlast !== want.last)
                report($sformatf("tlast %b want %b", i_m_tlast, want.last));
        end
    endtask

    initial begin
        o_mismatches = 0;
        o_seen = 0;
    end

    // Snoop all channels on the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg = WIDTH_W'(MAX_WIDTH);
            coef_rows[0] = '0;
            coef_rows[1] = 48'd16777216;
            coef_rows[2] = '0;
            restart_image();
            pixels_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:3])
                    REG_IMAGE_WIDTH: width_reg = i_pwdata[WIDTH_W-1:0];
                    REG_COEF_TOP:    coef_rows[0] = i_pwdata[ROW_COEF_W-1:0];
                    REG_COEF_MID:    coef_rows[1] = i_pwdata[ROW_COEF_W-1:0];
                    REG_COEF_BOT:    coef_rows[2] = i_pwdata[ROW_COEF_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) predict_item(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) compare_result();
        end
    end

endmodule

// ===== dv/conv3x3_normalized_clamp_tb.sv =====
// Testbench top of the 3x3 filter: clock, reset, stimulus, register writes and verdict.
module conv3x3_normalized_clamp_tb;
    import cnv_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE       = 200;
    localparam int RANDOM_ITEMS = 820;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic              m_tlast;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int mismatches, pending, seen;
    int cycles = 0;
    int items_sent = 0;
    int flushes_sent = 0;
    int images_run = 0;

    // Sender-side copy of the image position, used to end images cleanly.
    int gen_width = MAX_WIDTH;
    int gen_col = 0;
    int gen_rows = 0;

    always #10 i_clk = ~i_clk;

    conv3x3_normalized_clamp uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    conv3x3_normalized_clamp_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tlast(m_tlast),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_mismatches(mismatches), .o_pending(pending), .o_seen(seen)
    );

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("[conv3x3_normalized_clamp] ERROR");
            $finish;
        end
    end

    // Receiver: random stall before each result, sometimes none.
    initial begin
        int k;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            k = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (k > 0) begin
                m_tready <= 1'b0;
                repeat (k) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_tvalid && m_tready)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] pix);
        int k;
        k = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (k > 0) begin
            s_tvalid <= 1'b0;
            repeat (k) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= pix;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
        if (kind) flushes_sent++;
        // Track the position the way the block does.
        if (!kind) begin
            if (gen_col + 1 >= gen_width) begin
                gen_col = 0;
                if (gen_rows < 2) gen_rows++;
            end else begin
                gen_col++;
            end
        end else if (gen_rows == 0 || gen_col + 1 >= gen_width) begin
            gen_col = 0;
            gen_rows = 0;
        end else begin
            gen_col++;
        end
    endtask

    // Flush until the image restarts, so the width may change safely.
    task automatic finish_image();
        while (gen_rows != 0 || gen_col != 0) send_item(1'b1, 8'($urandom));
        images_run++;
    endtask

    // Wait for every result, then let the front end finish items that yield no result.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 3'b000});
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input int width, input logic [47:0] top,
                             input logic [47:0] mid, input logic [47:0] bot);
        quiesce();
        reg_write(REG_IMAGE_WIDTH, APB_DW'(width));
        reg_write(REG_COEF_TOP, APB_DW'(top));
        reg_write(REG_COEF_MID, APB_DW'(mid));
        reg_write(REG_COEF_BOT, APB_DW'(bot));
        gen_width = (width == 0) ? 1 : (width > MAX_WIDTH ? MAX_WIDTH : width);
    endtask

    function automatic logic [15:0] rand_tap(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom_range(0, 512));
        endcase
    endfunction

    function automatic logic [47:0] rand_row(input int mode);
        return {rand_tap(mode), rand_tap(mode), rand_tap(mode)};
    endfunction

    // Random image: random kernel, random size, mostly raster pixels with stray flushes.
    task automatic random_image();
        int w, rows, mode;
        logic [47:0] t, m, b;
        w = $urandom_range(0, 19) < 14 ? $urandom_range(1, 8)
          : ($urandom_range(0, 5) != 0 ? $urandom_range(9, 40) : $urandom_range(41, 100));
        mode = $urandom_range(0, 3);
        t = rand_row(mode);
        m = rand_row(mode);
        b = rand_row(mode);
        // Sometimes aim for a zero kernel sum so the fixed divisor is used.
        if ($urandom_range(0, 5) == 0) b[47:32] = -(t[15:0] + t[31:16] + t[47:32]
            + m[15:0] + m[31:16] + m[47:32] + b[15:0] + b[31:16]);
        configure(w, t, m, b);
        rows = $urandom_range(0, 4);
        for (int i = 0; i < rows * w; i++) begin
            if ($urandom_range(0, 11) == 0) send_item(1'b1, 8'($urandom));
            send_item(1'b0, 8'($urandom));
        end
        finish_image();
    endtask

    initial begin
        int base;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: flush with no complete row at reset width.
        send_item(1'b1, 8'h00);
        // Width 1, identity kernel, pixel extremes.
        configure(1, 48'd0, 48'd16777216, 48'd0);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h80);
        finish_image();
        // Largest positive taps on a bright image.
        configure(3, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        repeat (6) send_item(1'b0, 8'hFF);
        finish_image();
        // Most negative taps and all-ones patterns.
        configure(2, {3{16'h8000}}, {3{16'hFFFF}}, {3{16'h8000}});
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'h55);
        send_item(1'b0, 8'hAA);
        finish_image();
        // Width zero acts as one; zero kernel uses the fixed divisor.
        configure(0, 48'd0, 48'd0, 48'd0);
        send_item(1'b0, 8'h12);
        send_item(1'b0, 8'hED);
        finish_image();

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) random_image();

        quiesce();
        $display("covered %0d items (%0d flushes) over %0d images, %0d results checked",
                 items_sent, flushes_sent, images_run, seen);
        $display("widths 0 to 100, kernel extremes, zero kernel sums and stray flushes");
        if (mismatches == 0 && pending == 0) begin
            $display("[conv3x3_normalized_clamp] OK");
        end else begin
            $display("[conv3x3_normalized_clamp] ERROR");
        end
        $finish;
    end

endmodule
